// ===== rtl/csc_pkg.sv =====
package csc_pkg;

  localparam int IN_W  = 18;
  localparam int OUT_W = 18;

  // fixed-point precision of the elaboration-time series
  localparam int SERIES_FRAC = 60;
  localparam int ROM_FRAC    = 48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROT,
    ST_MUL
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last_step;
  } status_t;

  // shift-subtract quotient, evaluated only at elaboration
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    logic [64:0]     rem;
    longint unsigned quo;
    rem = '0;
    quo = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(1/n) in Q60 from the alternating power series
  function automatic longint unsigned atan_recip(input longint unsigned n);
    longint unsigned p;
    longint unsigned sq;
    longint unsigned sum;
    longint unsigned term;
    longint unsigned k;
    p   = udiv64(64'd1 << SERIES_FRAC, n);
    sq  = n * n;
    sum = 64'd0;
    k   = 64'd0;
    while (p != 64'd0) begin
      term = udiv64(p, 64'd2 * k + 64'd1);
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
      p = udiv64(p, sq);
      k = k + 64'd1;
    end
    return sum;
  endfunction

  function automatic longint unsigned isqrt64(input longint unsigned v_in);
    longint unsigned v;
    longint unsigned r;
    longint unsigned b;
    v = v_in;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > v) begin
      b = b >> 2;
    end
    while (b != 64'd0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // arctangent table entry, pi taken as 3.1415, 2^frac equals 90 degrees
  function automatic longint unsigned atan_entry(input int idx, input int frac);
    longint unsigned a;
    longint unsigned g;
    if (idx == 0) begin
      a = atan_recip(64'd2) + atan_recip(64'd3);
    end else begin
      a = atan_recip(64'd1 << idx);
    end
    g = ((a >> (SERIES_FRAC - ROM_FRAC)) * 64'd20000) / 64'd31415;
    return g >> (ROM_FRAC - frac);
  endfunction

  function automatic longint unsigned gain_kn(input int iters, input int frac);
    longint unsigned k2;
    k2 = 64'd1 << 62;
    for (int i = 0; i < iters; i++) begin
      k2 = k2 - udiv64(k2, (64'd1 << (2 * i)) + 64'd1);
    end
    return isqrt64(k2) >> (31 - frac);
  endfunction

endpackage

// ===== rtl/csc_ctrl.sv =====
module csc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output csc_pkg::cmd_t     cmd,
  input  csc_pkg::status_t  status
);

  csc_pkg::state_t state_r;
  csc_pkg::state_t state_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic            out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      csc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = csc_pkg::ST_ROT;
        end
      end
      csc_pkg::ST_ROT: begin
        if (status.last_step) begin
          state_nxt = csc_pkg::ST_MUL;
        end
      end
      csc_pkg::ST_MUL: begin
        if (out_free) begin
          state_nxt = csc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = csc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_stall     = 1'b1;
    case (state_r)
      csc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      csc_pkg::ST_ROT: begin
        cmd.step = 1'b1;
      end
      csc_pkg::ST_MUL: begin
        cmd.out_load = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  // result register is never overwritten while a stalled result waits
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == csc_pkg::ST_ROT))
    else $error("accepted item did not start rotating");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == csc_pkg::ST_ROT && status.last_step) |=> (state_r == csc_pkg::ST_MUL))
    else $error("rotation did not end after last step");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not shown");
`endif

endmodule

// ===== rtl/csc_dp.sv =====
module csc_dp #(
  parameter int ITERATIONS    = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  csc_pkg::cmd_t                     cmd,
  output csc_pkg::status_t                  status,
  input  logic signed [csc_pkg::IN_W-1:0]   in_target_angle,
  output logic signed [csc_pkg::OUT_W-1:0]  out_cos_value,
  output logic signed [csc_pkg::OUT_W-1:0]  out_sin_value
);

  localparam int F  = FRACTION_BITS;
  localparam int N  = ITERATIONS;
  localparam int W  = F + 3;
  localparam int AW = (F + 3 > csc_pkg::IN_W + 1) ? F + 3 : csc_pkg::IN_W + 1;
  localparam int CW = (N > 1) ? $clog2(N) : 1;
  localparam int KW = F + 1;
  localparam int PW = (2 * F + 4 > F + csc_pkg::OUT_W) ? 2 * F + 4 : F + csc_pkg::OUT_W;
  localparam longint unsigned KN = csc_pkg::gain_kn(N, F);

  logic [AW-1:0] rom [N];

  for (genvar g = 0; g < N; g++) begin : g_rom
    localparam longint unsigned ENTRY = csc_pkg::atan_entry(g, F);
    assign rom[g] = ENTRY[AW-1:0];
  end

  logic signed [W-1:0]  x_r, x_nxt;
  logic signed [W-1:0]  y_r, y_nxt;
  logic signed [AW-1:0] angle_r, angle_nxt;
  logic signed [AW-1:0] target_r;
  logic                 dir_r, dir_nxt;
  logic [CW-1:0]        cnt_r;
  logic signed [W-1:0]  xs, ys;
  logic signed [AW-1:0] step_angle;
  logic signed [PW-1:0] x_ext, y_ext, kn_ext;
  logic signed [PW-1:0] px, py;
  logic signed [csc_pkg::OUT_W-1:0] cos_r, sin_r;

  assign xs         = x_r >>> cnt_r;
  assign ys         = y_r >>> cnt_r;
  assign step_angle = $signed(rom[cnt_r]);

  always_comb begin
    if (dir_r) begin
      x_nxt     = x_r - ys;
      y_nxt     = y_r + xs;
      angle_nxt = angle_r + step_angle;
    end else begin
      x_nxt     = x_r + ys;
      y_nxt     = y_r - xs;
      angle_nxt = angle_r - step_angle;
    end
    dir_nxt = angle_nxt < target_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r      <= W'(1) <<< F;
      y_r      <= '0;
      angle_r  <= '0;
      dir_r    <= 1'b1;
      target_r <= AW'(in_target_angle);
    end else if (cmd.step) begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      angle_r <= angle_nxt;
      dir_r   <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= '0;
    end else if (cmd.step) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  assign status.last_step = (cnt_r == CW'(N - 1));

  // gain correction, full-width product then arithmetic shift by F
  assign x_ext  = PW'(x_r);
  assign y_ext  = PW'(y_r);
  assign kn_ext = PW'($signed({1'b0, KN[KW-1:0]}));
  assign px     = x_ext * kn_ext;
  assign py     = y_ext * kn_ext;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cos_r <= px[F + csc_pkg::OUT_W - 1:F];
      sin_r <= py[F + csc_pkg::OUT_W - 1:F];
    end
  end

  assign out_cos_value = cos_r;
  assign out_sin_value = sin_r;

endmodule

// ===== rtl/cordic_sin_cos.sv =====
// CORDIC sine/cosine in rotation mode. An item carries a signed 18-bit angle where
// 2^FRACTION_BITS is 90 degrees; the result gives cosine and sine scaled by
// 2^FRACTION_BITS, wrapped to 18 bits. One item is in work at a time. An item is
// loaded in the idle state, then the rotate state does one micro-rotation per cycle
// through the single shift-add unit, then the gain multiply writes the result
// register in the multiply state. With a free output the block returns to idle
// and takes the next item once the result register is written. A finished result
// waits in its own register, so the next item is taken while it is still stalled;
// a result that cannot be written because the previous one is still held stretches
// the multiply state until the output is free.
module cordic_sin_cos #(
  parameter int ITERATIONS    = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [csc_pkg::IN_W-1:0]   in_target_angle,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [csc_pkg::OUT_W-1:0]  out_cos_value,
  output logic signed [csc_pkg::OUT_W-1:0]  out_sin_value
);

  csc_pkg::cmd_t    cmd;
  csc_pkg::status_t status;

  csc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  csc_dp #(
    .ITERATIONS    (ITERATIONS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_target_angle (in_target_angle),
    .out_cos_value   (out_cos_value),
    .out_sin_value   (out_sin_value)
  );

endmodule

// ===== bench/tb_cordic_sin_cos.sv =====
`timescale 1ns / 1ps

module tb_cordic_sin_cos;

  localparam int ITERS      = 16;
  localparam int FRAC       = 16;
  localparam int IN_W       = csc_pkg::IN_W;
  localparam int OUT_W      = csc_pkg::OUT_W;
  localparam int RAND_ITEMS = 200;
  localparam int HOLD_LEN   = 300;
  localparam int LIMIT      = 300000;

  typedef struct packed {
    logic signed [OUT_W-1:0] cos_v;
    logic signed [OUT_W-1:0] sin_v;
  } trig_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [IN_W-1:0] in_target_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] out_cos_value;
  logic signed [OUT_W-1:0] out_sin_value;

  longint atan_tab [ITERS];
  longint kn_gain;
  trig_pair_t expected_q [$];
  int mismatch_count = 0;
  int send_idle_pct = 36;
  int recv_stall_pct = 49;
  int phase_no = 0;
  bit hold_off = 1'b0;
  int cycle_count = 0;

  // corners: zero, small steps, +-45/+-90 degrees, past the convergence range, input extremes
  logic signed [IN_W-1:0] corner_angles [0:19] = '{
    18'sd0, 18'sd1, -18'sd1, 18'sd2,
    18'sd65536, -18'sd65536, 18'sd65535, -18'sd65535,
    18'sd32768, -18'sd32768, 18'sd21845, -18'sd21845,
    18'sd43691, 18'sd72745, -18'sd72745, 18'sd100000,
    -18'sd100000, 18'sd80000, 18'sd131071, 18'sh20000
  };

  cordic_sin_cos #(
    .ITERATIONS   (ITERS),
    .FRACTION_BITS(FRAC)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_target_angle(in_target_angle),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cos_value  (out_cos_value),
    .out_sin_value  (out_sin_value)
  );

  always #5 clk = ~clk;

  // atan(1/n) in Q60 from the alternating power series, truncating each term
  function automatic longint unsigned series_atan_inv(input longint unsigned n);
    longint unsigned pw;
    longint unsigned total;
    pw = (64'd1 << 60) / n;
    total = 64'd0;
    for (longint unsigned k = 0; pw != 64'd0; k++) begin
      if (k[0]) begin
        total = total - pw / (64'd2 * k + 64'd1);
      end else begin
        total = total + pw / (64'd2 * k + 64'd1);
      end
      pw = pw / (n * n);
    end
    return total;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned trial;
    r = 64'd0;
    for (int b = 31; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= v) begin
        r = trial;
      end
    end
    return r;
  endfunction

  function automatic trig_pair_t predict_cos_sin(input logic signed [IN_W-1:0] angle);
    longint tgt;
    longint x;
    longint y;
    longint acc;
    longint xs;
    longint ys;
    longint prod_c;
    longint prod_s;
    bit up;
    trig_pair_t r;
    tgt = angle;
    x = longint'(1) << FRAC;
    y = 0;
    acc = 0;
    up = 1'b1;
    for (int i = 0; i < ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (up) begin
        x = x - ys;
        y = y + xs;
        acc = acc + atan_tab[i];
      end else begin
        x = x + ys;
        y = y - xs;
        acc = acc - atan_tab[i];
      end
      up = (acc < tgt);
    end
    prod_c = (x * kn_gain) >>> FRAC;
    prod_s = (y * kn_gain) >>> FRAC;
    r.cos_v = prod_c[OUT_W-1:0];
    r.sin_v = prod_s[OUT_W-1:0];
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input trig_pair_t want,
                               input trig_pair_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s: expected cos %0d sin %0d, got cos %0d sin %0d", $realtime, what,
               want.cos_v, want.sin_v, got.cos_v, got.sin_v);
    end
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_angle(input logic signed [IN_W-1:0] angle);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_target_angle <= angle;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    expected_q.push_back(predict_cos_sin(angle));
    @(negedge clk);
  endtask

  function automatic logic signed [IN_W-1:0] random_angle();
    int pick;
    int base;
    pick = $urandom_range(99);
    if (pick < 75) begin
      return IN_W'($urandom_range(131072) - 65536);
    end else if (pick < 88) begin
      return IN_W'($urandom);
    end
    // hover around the multiples of 45 degrees
    base = 32768 * ($urandom_range(4) - 2);
    return IN_W'(base + $urandom_range(16) - 8);
  endfunction

  // receiver
  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // long receiver hold-off while the sender keeps offering items
  initial begin
    wait (phase_no == 2);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    trig_pair_t got;
    trig_pair_t want;
    got.cos_v = out_cos_value;
    got.sin_v = out_sin_value;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        flag_mismatch("result with no item pending", '0, got);
      end else begin
        want = expected_q.pop_front();
        if (got.cos_v !== want.cos_v) begin
          flag_mismatch("cos mismatch", want, got);
        end else if (got.sin_v !== want.sin_v) begin
          flag_mismatch("sin mismatch", want, got);
        end
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    longint unsigned a;
    longint unsigned k2;
    k2 = 64'd1 << 62;
    for (int i = 0; i < ITERS; i++) begin
      if (i == 0) begin
        a = series_atan_inv(64'd2) + series_atan_inv(64'd3);
      end else begin
        a = series_atan_inv(64'd1 << i);
      end
      atan_tab[i] = longint'((((a >> 12) * 64'd20000) / 64'd31415) >> (48 - FRAC));
      k2 = k2 - k2 / ((64'd1 << (2 * i)) + 64'd1);
    end
    kn_gain = longint'(floor_sqrt(k2) >> (31 - FRAC));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (corner_angles[i]) begin
      send_angle(corner_angles[i]);
    end

    for (int p = 0; p < 3; p++) begin
      phase_no = p;
      send_idle_pct = (p == 0) ? 36 : (p == 1) ? 49 : 0;
      recv_stall_pct = (p == 0) ? 49 : (p == 1) ? 36 : 0;
      repeat (RAND_ITEMS) send_angle(random_angle());
    end
    in_valid <= 1'b0;

    while (expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (ITERS + 8) @(posedge clk);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
